>>> src/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication
`define LKVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> src/lkvc_pkg.sv
package lkvc_pkg;

	localparam int KEY_W  = 16;
	localparam int VAL_W  = 16;
	localparam int CAP_W  = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// word index of the capacity register (paddr bit 2)
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// running result of the lookup wave, one hop per cell per cycle
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] tail_key;
	} scan_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_HIT,
		MODE_INSERT,
		MODE_EVICT
	} mode_t;

	typedef struct packed {
		logic  apply;
		mode_t mode;
	} ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

>>> src/lkvc_cell.sv
module lkvc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lkvc_pkg::KEY_W-1:0] req_key,
	input  lkvc_pkg::ctl_t            ctl,
	input  lkvc_pkg::entry_t          left_entry,
	input  lkvc_pkg::scan_t           left_scan,
	output lkvc_pkg::entry_t          entry,
	output lkvc_pkg::scan_t           scan
);

	logic                       valid_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] value_q;
	lkvc_pkg::scan_t            scan_q;
	lkvc_pkg::scan_t            scan_d;
	logic                       match;
	logic                       shift;

	always_comb begin
		match           = valid_q && (key_q == req_key);
		scan_d.found    = left_scan.found | match;
		// first match wins; cells left of it have no match
		scan_d.value    = left_scan.found ? left_scan.value : value_q;
		// valid entries are packed from the head, so the last valid key is the oldest
		scan_d.tail_key = valid_q ? key_q : left_scan.tail_key;
	end

	always_comb begin
		case (ctl.mode)
			lkvc_pkg::MODE_HIT:    shift = !left_scan.found;
			lkvc_pkg::MODE_INSERT: shift = left_entry.valid;
			lkvc_pkg::MODE_EVICT:  shift = valid_q;
			default:               shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.apply && shift) begin
			valid_q <= left_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply && shift) begin
			key_q   <= left_entry.key;
			value_q <= left_entry.value;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;
	assign scan        = scan_q;

endmodule

>>> src/lkvc_cfg.sv
module lkvc_cfg #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
	input  logic [lkvc_pkg::DATA_W-1:0] pwdata,
	output logic [lkvc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic [CNT_W-1:0]            count,
	output logic                        at_capacity
);

	localparam int EW = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic [EW-1:0]              cap_ext;
	logic [EW-1:0]              eff_cap;
	logic [EW-1:0]              count_ext;
	logic                       reg_sel;

	assign reg_sel = (paddr[2] == lkvc_pkg::REG_CAPACITY);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[lkvc_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(lkvc_pkg::DATA_W-lkvc_pkg::CAP_W){1'b0}}, capacity_q};
		end
	end

	// zero acts as one, anything above the cell count acts as the cell count
	always_comb begin
		cap_ext   = EW'(capacity_q);
		count_ext = EW'(count);
		if (capacity_q == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(CAPACITY)) begin
			eff_cap = EW'(CAPACITY);
		end else begin
			eff_cap = cap_ext;
		end
		at_capacity = (count_ext >= eff_cap);
	end

endmodule

>>> src/lru_key_value_cache.sv
// result: registered once the lookup wave has crossed the chain and any earlier
//   result has been accepted; a new request is taken only when idle, and the wave
//   steps one cell per cycle down the chain of CAPACITY cells before the update
// entries are kept in recency order, head cell most recent
// reset: async active low, store empty, capacity register 16, no clearing pass
module lru_key_value_cache #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [lkvc_pkg::KEY_W-1:0]  key,
	input  logic [lkvc_pkg::VAL_W-1:0]  value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lkvc_pkg::VAL_W-1:0]  read_value,
	output logic                        evicted,
	output logic [lkvc_pkg::KEY_W-1:0]  evicted_key,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
	input  logic [lkvc_pkg::DATA_W-1:0] pwdata,
	output logic [lkvc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	lkvc_pkg::state_t           state_q;
	lkvc_pkg::state_t           state_d;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           count_q;
	logic                       op_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] value_q;

	logic                       out_valid_q;
	logic                       hit_q;
	logic [lkvc_pkg::VAL_W-1:0] read_value_q;
	logic                       evicted_q;
	logic [lkvc_pkg::KEY_W-1:0] evicted_key_q;

	logic                       at_capacity;
	logic                       finish;
	lkvc_pkg::ctl_t             ctl;
	lkvc_pkg::entry_t           head;
	lkvc_pkg::scan_t            scan_init;
	lkvc_pkg::scan_t            fin;

	lkvc_pkg::entry_t           cell_entry [CAPACITY];
	lkvc_pkg::scan_t            cell_scan  [CAPACITY];

	lkvc_cfg #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.count       (count_q),
		.at_capacity (at_capacity)
	);

	assign scan_init = '0;
	assign fin       = cell_scan[CAPACITY-1];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				lkvc_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.req_key    (key_q),
					.ctl        (ctl),
					.left_entry (head),
					.left_scan  (scan_init),
					.entry      (cell_entry[gi]),
					.scan       (cell_scan[gi])
				);
			end else begin : g_body
				lkvc_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.req_key    (key_q),
					.ctl        (ctl),
					.left_entry (cell_entry[gi-1]),
					.left_scan  (cell_scan[gi-1]),
					.entry      (cell_entry[gi]),
					.scan       (cell_scan[gi])
				);
			end
		end
	endgenerate

	// wave has reached the last cell once cnt_q counts CAPACITY
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lkvc_pkg::ST_SCAN;
				end
			end
			lkvc_pkg::ST_SCAN: begin
				if ((cnt_q == CNT_W'(CAPACITY)) && (!out_valid_q || out_ready)) begin
					finish  = 1'b1;
					state_d = lkvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.apply = finish;
		if (fin.found) begin
			ctl.mode = lkvc_pkg::MODE_HIT;
		end else if (op_q == lkvc_pkg::OP_PUT) begin
			ctl.mode = at_capacity ? lkvc_pkg::MODE_EVICT : lkvc_pkg::MODE_INSERT;
		end else begin
			ctl.mode = lkvc_pkg::MODE_HOLD;
		end
		head.valid = 1'b1;
		head.key   = key_q;
		head.value = (op_q == lkvc_pkg::OP_PUT) ? value_q : fin.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				cnt_q <= '0;
			end else if (state_q == lkvc_pkg::ST_SCAN && cnt_q != CNT_W'(CAPACITY)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (finish && ctl.mode == lkvc_pkg::MODE_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q         <= fin.found;
			read_value_q  <= (fin.found && op_q == lkvc_pkg::OP_GET) ? fin.value : '0;
			evicted_q     <= (ctl.mode == lkvc_pkg::MODE_EVICT);
			evicted_key_q <= (ctl.mode == lkvc_pkg::MODE_EVICT) ? fin.tail_key : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

>>> src/lkvc_checker.sv
`include "assert_macros.svh"

module lkvc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        hit,
	input logic [lkvc_pkg::VAL_W-1:0]  read_value,
	input logic                        evicted,
	input logic [lkvc_pkg::KEY_W-1:0]  evicted_key
);

	// an eviction only comes from a put that missed
	`LKVC_ASSERT_IMP(a_evict_on_miss, clk, arst_n, out_valid && evicted, !hit)

	`LKVC_ASSERT_IMP(a_evkey_zero, clk, arst_n, out_valid && !evicted, evicted_key == '0)

	// not found reads back as zero
	`LKVC_ASSERT_IMP(a_miss_reads_zero, clk, arst_n, out_valid && !hit, read_value == '0)

	// one request in flight at a time
	`LKVC_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	`LKVC_ASSERT_NXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(evicted_key))

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
